>>> design/wal_record_checksum_verifier_core_assert.svh
// ----------------------------------------------------------------------------
// WAL record checksum verifier: assertion macros
// Concurrent assertion wrappers; they expand to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef WAL_RECORD_CHECKSUM_VERIFIER_CORE_ASSERT_SVH
`define WAL_RECORD_CHECKSUM_VERIFIER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define WRCV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication
`define WRCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define WRCV_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WRCV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/wrcv_pkg.sv
// ----------------------------------------------------------------------------
// WAL record checksum verifier package
// Frame layout constants, FNV-1a 64 constants, status codes and decoders.
// ----------------------------------------------------------------------------
package wrcv_pkg;

	localparam int unsigned PosW = 5;

	// Frame layout: "WAL2 " prefix, 16 hex digits, one space, then payload
	localparam logic [PosW-1:0] PrefixLen  = 5'd5;
	localparam logic [PosW-1:0] DigitsEnd  = 5'd21;
	localparam logic [PosW-1:0] PayloadPos = 5'd22;
	localparam logic [7:0]      SpaceChar  = 8'h20;

	localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
	localparam logic [63:0] FnvPrime = 64'h00000100000001b3;

	typedef enum logic [1:0] {
		ST_PLAIN    = 2'd0,
		ST_VERIFIED = 2'd1,
		ST_FAILED   = 2'd2
	} line_status_t;

	// Decoded hex digit: valid flag and nibble
	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_digit_t;

	// Expected prefix byte at each of the first five positions
	function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h57; // W
			3'd1: c = 8'h41; // A
			3'd2: c = 8'h4c; // L
			3'd3: c = 8'h32; // 2
			3'd4: c = SpaceChar;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Decode one ASCII hex digit, either case
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.valid = 1'b0;
		d.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.valid = 1'b1;
			d.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d.valid = 1'b1;
			d.value = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d.valid = 1'b1;
			d.value = 4'(c - 8'h37);
		end
		return d;
	endfunction

endpackage

>>> design/wrcv_fnv_step.sv
// ----------------------------------------------------------------------------
// FNV-1a 64 step
// Folds one byte into the hash: xor, then multiply by the FNV prime.
// ----------------------------------------------------------------------------
module wrcv_fnv_step
	import wrcv_pkg::*;
(
	input  logic [63:0] hash,
	input  logic [7:0]  data,
	output logic [63:0] hash_next
);

	logic [63:0] mixed;

	// Prime is 2^40 + 0x1b3; sum the shifted terms modulo 2^64
	assign mixed = hash ^ {56'd0, data};
	assign hash_next = (FnvPrime[40] ? (mixed << 40) : 64'd0)
		+ (mixed << 8) + (mixed << 7) + (mixed << 5)
		+ (mixed << 4) + (mixed << 1) + mixed;

endmodule

>>> design/wal_record_checksum_verifier_core.sv
// ----------------------------------------------------------------------------
// WAL record checksum verifier core
// Frames a log line byte by byte and checks its FNV-1a 64 checksum header.
// ----------------------------------------------------------------------------
// One byte of a log line is taken per clock while in_ready is high, with
// line_end on the last byte. A byte is registered in an input stage and then
// folded into the frame state (prefix match, hex checksum, FNV-1a 64 hash); a
// byte can be accepted every cycle unless a line end is stalled there. The
// checksum result is computed from the input stage on the last byte and held in
// an output register; further bytes of the next line keep flowing while it
// waits, and only the next line's last byte waits for that register to free.
// The per-byte hash multiply by the FNV prime is the longest path.
// ----------------------------------------------------------------------------
`include "wal_record_checksum_verifier_core_assert.svh"

module wal_record_checksum_verifier_core
	import wrcv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  line_byte,
	input  logic        line_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  line_status,
	output logic [63:0] payload_hash
);

	// Input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	// Frame state
	logic [PosW-1:0] pos_q;
	logic            prefix_q;
	logic            err_q;
	logic [63:0]     exp_q;
	logic [63:0]     hash_q;

	// Result register
	logic         out_valid_q;
	line_status_t status_q;
	logic [63:0]  result_q;

	logic            advance;
	logic [PosW-1:0] pos_next;
	logic            prefix_next;
	logic            err_next;
	logic [63:0]     exp_next;
	logic [63:0]     hash_next;
	logic [63:0]     hash_step;
	hex_digit_t      digit;
	line_status_t    status_next;
	logic [63:0]     result_next;

	// Retire the staged item; only a line end needs the result slot
	assign advance = valid_s1 && (!end_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	wrcv_fnv_step u_fnv_step (
		.hash      (hash_q),
		.data      (byte_s1),
		.hash_next (hash_step)
	);

	assign digit = hex_decode(byte_s1);

	// Parse the staged byte against the frame position
	always_comb begin
		pos_next    = pos_q;
		prefix_next = prefix_q;
		err_next    = err_q;
		exp_next    = exp_q;
		hash_next   = hash_q;
		if (pos_q < PrefixLen) begin
			if (byte_s1 != prefix_byte(pos_q[2:0])) begin
				prefix_next = 1'b0;
			end
		end else if (pos_q < DigitsEnd) begin
			if (!digit.valid) begin
				err_next = 1'b1;
			end else begin
				exp_next = {exp_q[59:0], digit.value};
			end
		end else if (pos_q == DigitsEnd) begin
			if (byte_s1 != SpaceChar) begin
				err_next = 1'b1;
			end
		end else begin
			hash_next = hash_step;
		end
		if (pos_q < PayloadPos) begin
			pos_next = pos_q + PosW'(1);
		end
	end

	// Classify the line on its last byte
	always_comb begin
		result_next = hash_next;
		if (!prefix_next || pos_q < (PrefixLen - PosW'(1))) begin
			status_next = ST_PLAIN;
			result_next = 64'd0;
		end else if (pos_q < DigitsEnd || err_next) begin
			status_next = ST_FAILED;
		end else if (hash_next == exp_q) begin
			status_next = ST_VERIFIED;
		end else begin
			status_next = ST_FAILED;
		end
	end

	// Hold the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= line_byte;
			end_s1  <= line_end;
		end
	end

	// Advance the frame state; drop back to reset at a line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			prefix_q <= 1'b1;
			err_q    <= 1'b0;
			exp_q    <= 64'd0;
			hash_q   <= FnvBasis;
		end else if (advance) begin
			if (end_s1) begin
				pos_q    <= '0;
				prefix_q <= 1'b1;
				err_q    <= 1'b0;
				exp_q    <= 64'd0;
				hash_q   <= FnvBasis;
			end else begin
				pos_q    <= pos_next;
				prefix_q <= prefix_next;
				err_q    <= err_next;
				exp_q    <= exp_next;
				hash_q   <= hash_next;
			end
		end
	end

	// Load the result register on a line end, clear it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			status_q <= status_next;
			result_q <= result_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign line_status  = status_q;
	assign payload_hash = result_q;

	// Checks
	`WRCV_ASSERT_NEXT(a_end_loads_result, clk, arst_n,
		advance && end_s1, out_valid_q && pos_q == '0 && hash_q == FnvBasis)
	`WRCV_ASSERT_NOW(a_pos_saturates, clk, arst_n, 1'b1, pos_q <= PayloadPos)
	`WRCV_ASSERT_NOW(a_plain_zero_hash, clk, arst_n,
		out_valid_q && status_q == ST_PLAIN, result_q == 64'd0)
	`WRCV_ASSERT_NEXT(a_body_keeps_result, clk, arst_n,
		advance && !end_s1 && out_valid_q && !out_ready,
		out_valid_q && $stable(result_q))

endmodule
